/* rtl/spq_pkg.sv */
// Shared types, codes and defaults for the four-level strict priority ready queue.
package spq_pkg;

  // Number of priority levels and the width of a level number.
  localparam int NUM_LEVELS = 4;
  localparam int LVL_BITS   = 2;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int DEF_LEVEL_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // Command carried on the input tuser.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Outcome reported with every result word.
  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_ENQUEUED  = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Control from the top level to one level's queue.
  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctrl_t;

  // Occupancy flags from one level's queue.
  typedef struct packed {
    logic empty;
    logic full;
  } lvl_stat_t;

endpackage

/* rtl/strict_priority_ready_queue_top.sv */
// A result word is registered: it appears in the output register in the cycle after its command is taken.
// Throughput: one command per cycle, sustained while the output side keeps taking results;
// each level is a row of cells that shifts by one place per pop, so no step takes longer.
// Reset (rst_n low, synchronous) empties every level and drops any pending result word;
// the stored ids are not cleared, as an empty cell is never read.
module strict_priority_ready_queue_top #(
  parameter int LEVEL_DEPTH = spq_pkg::DEF_LEVEL_DEPTH,
  parameter int ID_BITS     = spq_pkg::DEF_ID_BITS,
  localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1),
  localparam int TOT_W      = $clog2(spq_pkg::NUM_LEVELS * LEVEL_DEPTH + 1),
  localparam int IN_BITS    = ID_BITS + spq_pkg::LVL_BITS + 1,
  localparam int IN_DW      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ID_BITS + spq_pkg::LVL_BITS + spq_pkg::NUM_LEVELS * CNT_W + TOT_W,
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Command channel.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // thread_id, level, is_ready, zero padding
  input  logic              in_tuser,   // command
  // Result channel.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // chosen_id, chosen_level, count_system,
                                        // count_interactive, count_normal, count_batch,
                                        // total_waiting, zero padding
  output logic [2:0]        out_tuser   // status
);
  import spq_pkg::*;

  // Unpacked command word.
  logic                cmd;
  logic [ID_BITS-1:0]  in_id;
  logic [LVL_BITS-1:0] in_lvl;
  logic                in_rdy;
  logic                accept;

  // The output register holds a result word until the output side takes it.
  logic                out_tvalid_r;

  assign cmd    = in_tuser;
  assign in_id  = in_tdata[ID_BITS-1:0];
  assign in_lvl = in_tdata[ID_BITS +: LVL_BITS];
  assign in_rdy = in_tdata[ID_BITS + LVL_BITS];

  // A new command is taken whenever the output register is free or is being emptied.
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Per-level queues.
  lvl_ctrl_t          ctrl     [NUM_LEVELS];
  lvl_stat_t          stat     [NUM_LEVELS];
  logic [ID_BITS-1:0] head_id  [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_nxt  [NUM_LEVELS];

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
    spq_level #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ID_BITS     (ID_BITS),
      .CNT_W       (CNT_W)
    ) u_level (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[l]),
      .wr_id     (in_id),
      .stat      (stat[l]),
      .head_id   (head_id[l]),
      .count_nxt (cnt_nxt[l])
    );
  end

  // Strict priority: the lowest-numbered level holding an entry wins a dequeue.
  logic                sel_valid;
  logic [LVL_BITS-1:0] sel_lvl;

  always_comb begin
    sel_valid = 1'b0;
    sel_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (!stat[i].empty) begin
        sel_valid = 1'b1;
        sel_lvl   = LVL_BITS'(i);
      end
    end
  end

  // Command decode. A readiness check comes before the fullness check on an enqueue.
  status_t             status_nxt;
  logic [ID_BITS-1:0]  chosen_id_nxt;
  logic [LVL_BITS-1:0] chosen_lvl_nxt;

  always_comb begin
    status_nxt     = ST_EMPTY;
    chosen_id_nxt  = '0;
    chosen_lvl_nxt = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ctrl[i] = '0;
    end
    if (cmd == CMD_ENQ) begin
      if (!in_rdy) begin
        status_nxt = ST_NOT_READY;
      end else if (stat[in_lvl].full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt           = ST_ENQUEUED;
        ctrl[in_lvl].push    = accept;
      end
    end else if (sel_valid) begin
      status_nxt         = ST_SCHEDULED;
      chosen_id_nxt      = head_id[sel_lvl];
      chosen_lvl_nxt     = sel_lvl;
      ctrl[sel_lvl].pop  = accept;
    end
  end

  // Output register. The counts are those after the command has taken effect.
  status_t             status_r;
  logic [ID_BITS-1:0]  chosen_id_r;
  logic [LVL_BITS-1:0] chosen_lvl_r;
  logic [CNT_W-1:0]    cnt_r [NUM_LEVELS];
  logic [TOT_W-1:0]    total_r;
  logic [TOT_W-1:0]    total_nxt;

  assign total_nxt = TOT_W'(cnt_nxt[0]) + TOT_W'(cnt_nxt[1])
                   + TOT_W'(cnt_nxt[2]) + TOT_W'(cnt_nxt[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      chosen_id_r  <= chosen_id_nxt;
      chosen_lvl_r <= chosen_lvl_nxt;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      total_r      <= total_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_DW'({total_r, cnt_r[3], cnt_r[2], cnt_r[1], cnt_r[0],
                               chosen_lvl_r, chosen_id_r});

  // The reported total always agrees with the four reported counts.
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> total_r == (TOT_W'(cnt_r[0]) + TOT_W'(cnt_r[1])
                               + TOT_W'(cnt_r[2]) + TOT_W'(cnt_r[3])))
    else $error("total_waiting disagrees with the level counts");

  // A dequeue taken while some level holds an entry must schedule a thread.
  a_dequeue_wins: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_DEQ) && sel_valid |=> out_tvalid_r && (status_r == ST_SCHEDULED))
    else $error("dequeue with waiting entries was not scheduled");

  // Only a scheduled result carries a thread id and level.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (status_r != ST_SCHEDULED) |-> (chosen_id_r == '0) && (chosen_lvl_r == '0))
    else $error("chosen fields set without a scheduled thread");

  // No level ever reports more entries than it can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (cnt_r[0] <= CNT_W'(LEVEL_DEPTH)) && (cnt_r[1] <= CNT_W'(LEVEL_DEPTH))
                  && (cnt_r[2] <= CNT_W'(LEVEL_DEPTH)) && (cnt_r[3] <= CNT_W'(LEVEL_DEPTH)))
    else $error("level count beyond its depth");

endmodule

/* rtl/spq_cell.sv */
// One storage cell of a level queue: holds one thread id and takes its neighbour's on a pop.
module spq_cell #(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               shift,
  input  logic               load,
  input  logic [ID_BITS-1:0] wr_id,
  input  logic [ID_BITS-1:0] nbr_id,
  output logic [ID_BITS-1:0] id_q
);

  logic [ID_BITS-1:0] data_r;

  // A pop moves every entry one cell towards the head; a push fills the first free cell.
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= nbr_id;
    end else if (load) begin
      data_r <= wr_id;
    end
  end

  assign id_q = data_r;

endmodule

/* rtl/spq_level.sv */
// One priority level: a row of cells forming a shifting first-in first-out queue with its count.
module spq_level #(
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int CNT_W       = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_pkg::lvl_ctrl_t       ctrl,
  input  logic [ID_BITS-1:0]       wr_id,
  output spq_pkg::lvl_stat_t       stat,
  output logic [ID_BITS-1:0]       head_id,
  output logic [CNT_W-1:0]         count_nxt
);
  import spq_pkg::*;

  logic [CNT_W-1:0]   count_r;
  logic [ID_BITS-1:0] cell_q [LEVEL_DEPTH];

  // Cell 0 is always the oldest entry; the entry count marks the first free cell.
  for (genvar g = 0; g < LEVEL_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] nbr;
    if (g == LEVEL_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end
    spq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk    (clk),
      .shift  (ctrl.pop),
      .load   (ctrl.push && (count_r == CNT_W'(g))),
      .wr_id  (wr_id),
      .nbr_id (nbr),
      .id_q   (cell_q[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(LEVEL_DEPTH));
  assign head_id    = cell_q[0];

endmodule

/* dv/strict_priority_ready_queue_top_tb.sv */
// Self-checking testbench for the four-level strict priority ready queue top level.
module strict_priority_ready_queue_top_tb;
  import spq_pkg::*;

  // The block is built with its default sizing, so the widths below follow it.
  localparam int DEPTH   = spq_pkg::DEF_LEVEL_DEPTH;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 40;
  localparam int HOLD_CYCLES = 400;

  // One command word as the sender offers it.
  typedef struct packed {
    logic       cmd;
    logic [7:0] tid;
    logic [1:0] lvl;
    logic       rdy;
  } cmd_word_t;

  // One result word as the block should return it.
  typedef struct packed {
    status_t    status;
    logic [7:0] id;
    logic [1:0] lvl;
    logic [4:0] cnt_sys;
    logic [4:0] cnt_int;
    logic [4:0] cnt_nrm;
    logic [4:0] cnt_bat;
    logic [6:0] total;
  } result_word_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata   = '0;  // thread_id, level, is_ready, zero padding
  logic              in_tuser   = 1'b0; // command
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;  // chosen_id, chosen_level, count_system,
                                 // count_interactive, count_normal, count_batch,
                                 // total_waiting, zero padding
  logic [2:0]        out_tuser;  // status

  strict_priority_ready_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // The clock period is two time units.
  always #1 clk = ~clk;

  // Commands waiting to be offered, and the results the block still owes us.
  cmd_word_t    pending_cmds[$];
  result_word_t expected_results[$];
  cmd_word_t    offered_cmd;

  // Our own image of the queue: one ring of ids per level, with its pointers and fill.
  logic [7:0] ring_ids [NUM_LEVELS][DEPTH];
  int         ring_head[NUM_LEVELS];
  int         ring_tail[NUM_LEVELS];
  int         ring_fill[NUM_LEVELS];

  // Idle rates in percent for each side, and the long receiver hold-off.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_go       = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_left     = 0;

  int mismatch_count = 0;

  // Prints one line per discrepancy and keeps count; the run carries on regardless.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Applies one command to the queue image and works out the result word it yields.
  // Readiness is judged before fullness, and a dequeue ignores every other field.
  task automatic schedule_step(input cmd_word_t c, output result_word_t r);
    int   lv;
    logic found;
    r     = '0;
    found = 1'b0;
    if (c.cmd == CMD_ENQ) begin
      if (!c.rdy) begin
        r.status = ST_NOT_READY;
      end else if (ring_fill[c.lvl] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        ring_ids[c.lvl][ring_tail[c.lvl]] = c.tid;
        ring_tail[c.lvl] = (ring_tail[c.lvl] == DEPTH - 1) ? 0 : ring_tail[c.lvl] + 1;
        ring_fill[c.lvl]++;
        r.status = ST_ENQUEUED;
      end
    end else begin
      r.status = ST_EMPTY;
      for (lv = 0; lv < NUM_LEVELS; lv++) begin
        if (!found && ring_fill[lv] != 0) begin
          found    = 1'b1;
          r.id     = ring_ids[lv][ring_head[lv]];
          r.lvl    = lv[1:0];
          ring_head[lv] = (ring_head[lv] == DEPTH - 1) ? 0 : ring_head[lv] + 1;
          ring_fill[lv]--;
          r.status = ST_SCHEDULED;
        end
      end
    end
    r.cnt_sys = ring_fill[0][4:0];
    r.cnt_int = ring_fill[1][4:0];
    r.cnt_nrm = ring_fill[2][4:0];
    r.cnt_bat = ring_fill[3][4:0];
    r.total   = 7'(ring_fill[0] + ring_fill[1] + ring_fill[2] + ring_fill[3]);
  endtask

  task automatic add_cmd(input logic cmd, input logic [7:0] tid, input logic [1:0] lvl,
                         input logic rdy);
    cmd_word_t c;
    c.cmd = cmd;
    c.tid = tid;
    c.lvl = lvl;
    c.rdy = rdy;
    pending_cmds.push_back(c);
  endtask

  // Driver. A word is taken at an edge where tvalid and tready were both high; the
  // prediction is made at that very edge, so the expected results stay in order.
  // A new word is loaded only once the previous one has gone, so tvalid is never
  // dropped and raised within one step.
  always @(posedge clk) begin
    result_word_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        schedule_step(offered_cmd, r);
        expected_results.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_cmd = pending_cmds.pop_front();
          in_tdata    <= {5'b0, offered_cmd.rdy, offered_cmd.lvl, offered_cmd.tid};
          in_tuser    <= offered_cmd.cmd;
          in_tvalid   <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure. The long hold-off is counted here, in cycles, so that the
  // block fills up and has to stall its input while the sender keeps offering words.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: every word taken on the result side is compared, field by field, with the
  // oldest expectation.
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", {out_tuser, out_tdata}, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", out_tuser, want.status);
        if (out_tdata[7:0] !== want.id)
          report_mismatch("chosen_id", out_tdata[7:0], want.id);
        if (out_tdata[9:8] !== want.lvl)
          report_mismatch("chosen_level", out_tdata[9:8], want.lvl);
        if (out_tdata[14:10] !== want.cnt_sys)
          report_mismatch("count_system", out_tdata[14:10], want.cnt_sys);
        if (out_tdata[19:15] !== want.cnt_int)
          report_mismatch("count_interactive", out_tdata[19:15], want.cnt_int);
        if (out_tdata[24:20] !== want.cnt_nrm)
          report_mismatch("count_normal", out_tdata[24:20], want.cnt_nrm);
        if (out_tdata[29:25] !== want.cnt_bat)
          report_mismatch("count_batch", out_tdata[29:25], want.cnt_bat);
        if (out_tdata[36:30] !== want.total)
          report_mismatch("total_waiting", out_tdata[36:30], want.total);
        if (out_tdata[39:37] !== 3'b000)
          report_mismatch("tdata padding", out_tdata[39:37], 0);
      end
    end
  end

  // Builds random traffic in runs of forty words. Each run leans towards filling, stays
  // balanced or leans towards draining, and favours one level, so that levels reach full and empty often and the
  // rings wrap; the remainder is scattered noise and threads that are not ready.
  task automatic add_random_cmds(input int n);
    int i;
    int enq_pct;
    int focus;
    logic [1:0] lvl;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 20;
        endcase
        focus = $urandom_range(NUM_LEVELS - 1);
      end
      lvl = ($urandom_range(99) < 60) ? focus[1:0] : 2'($urandom_range(3));
      // A dequeue still carries random garbage in the fields it ignores.
      add_cmd(($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ, 8'($urandom_range(255)),
              lvl, ($urandom_range(99) < 88));
    end
  endtask

  // Waits until every queued word has been taken and every result has come back.
  task automatic wait_drained;
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_LEVELS; i++) begin
      ring_head[i] = 0;
      ring_tail[i] = 0;
      ring_fill[i] = 0;
    end

    // Reset is held once, at the start of the run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the first idling pattern.
    send_idle_pct = 36;
    recv_idle_pct = 78;
    // Dequeue from an empty queue, then a thread that is not ready.
    add_cmd(CMD_DEQ, 8'hff, 2'd3, 1'b1);
    add_cmd(CMD_ENQ, 8'h11, 2'd0, 1'b0);
    // Fill the normal level to the brim, with the extreme ids among the entries.
    add_cmd(CMD_ENQ, 8'h00, 2'd2, 1'b1);
    add_cmd(CMD_ENQ, 8'hff, 2'd2, 1'b1);
    for (i = 2; i < DEPTH; i++)
      add_cmd(CMD_ENQ, 8'(i * 17), 2'd2, 1'b1);
    // One more is dropped as full; a not-ready thread to a full level reports not ready.
    add_cmd(CMD_ENQ, 8'h5a, 2'd2, 1'b1);
    add_cmd(CMD_ENQ, 8'h5b, 2'd2, 1'b0);
    // Entries at the other levels, then dequeues that must follow strict priority.
    add_cmd(CMD_ENQ, 8'hff, 2'd3, 1'b1);
    add_cmd(CMD_ENQ, 8'h00, 2'd1, 1'b1);
    add_cmd(CMD_ENQ, 8'hff, 2'd0, 1'b1);
    add_cmd(CMD_DEQ, 8'h00, 2'd0, 1'b0);
    add_cmd(CMD_DEQ, 8'hff, 2'd3, 1'b1);
    add_cmd(CMD_DEQ, 8'ha5, 2'd1, 1'b0);

    // Random part, first phase: the sender idles a little, the receiver a lot.
    add_random_cmds(250);
    wait_drained();

    // Second phase: the idling swapped round.
    send_idle_pct = 78;
    recv_idle_pct = 36;
    add_random_cmds(250);
    wait_drained();

    // Third phase: neither side idles, after a long receiver hold-off at its start.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_cmds(250);
    hold_go = 1'b1;
    wait_drained();

    // Wait a while longer so that any stray result word can show itself.
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still owed at the end", 0, expected_results.size());
    if (mismatch_count == 0) begin
      $display("strict_priority_ready_queue_top test passed");
    end else begin
      $display("strict_priority_ready_queue_top test failed");
    end
    $finish;
  end

  // Watchdog: a run that outlasts this bound is reported as failed.
  initial begin
    #400000;
    $display("strict_priority_ready_queue_top test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_level.sv
rtl/strict_priority_ready_queue_top.sv
dv/strict_priority_ready_queue_top_tb.sv
